// ----- rtl/core/vcva_pkg.sv -----
// Package for the voice allocator: constants, operation codes and the
// command and status structures shared by controller and datapath. No dependencies.
package vcva_pkg;

  localparam int MaxVoices     = 32;
  localparam int MaxTracks     = 64;
  localparam int NumChan       = MaxTracks + MaxVoices;
  localparam int VoicesPerChan = 16;

  localparam logic [1:0] FuncTrigger = 2'd0;
  localparam logic [1:0] FuncCut     = 2'd1;
  localparam logic [1:0] FuncPast    = 2'd2;
  localparam logic [1:0] FuncStatus  = 2'd3;

  localparam logic [2:0] KindStart   = 3'd0;
  localparam logic [2:0] KindSilence = 3'd1;
  localparam logic [2:0] KindReject  = 3'd2;
  localparam logic [2:0] KindStatus  = 3'd3;
  localparam logic [2:0] KindDone    = 3'd4;

  localparam logic [2:0] StatFg      = 3'd4;
  localparam logic [2:0] StatInvalid = 3'd5;

  localparam logic [1:0] CfgTracks = 2'd0;
  localparam logic [1:0] CfgVoices = 2'd1;
  localparam logic [1:0] CfgMulti  = 2'd2;

  localparam logic [3:0] OpNone     = 4'd0;
  localparam logic [3:0] OpLoad     = 4'd1;
  localparam logic [3:0] OpDup      = 4'd2;
  localparam logic [3:0] OpCutCh    = 4'd3;
  localparam logic [3:0] OpPast     = 4'd4;
  localparam logic [3:0] OpMap      = 4'd5;
  localparam logic [3:0] OpScanFree = 4'd6;
  localparam logic [3:0] OpScanOld  = 4'd7;
  localparam logic [3:0] OpApply    = 4'd8;
  localparam logic [3:0] OpScanBg   = 4'd9;
  localparam logic [3:0] OpMove     = 4'd10;
  localparam logic [3:0] OpFinish   = 4'd11;
  localparam logic [3:0] OpDone     = 4'd12;
  localparam logic [3:0] OpReject   = 4'd13;
  localparam logic [3:0] OpStatus   = 4'd14;

  typedef struct packed {
    logic [3:0] op;
    logic [6:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       inrange;
    logic       dup_en;
    logic       map_valid;
    logic       sounding;
    logic       multi;
    logic       lt_per;
    logic       found;
    logic       vf_ne_voc;
    logic       had_voc;
    logic       strict;
    logic [4:0] nv_last;
    logic [6:0] bg_first;
    logic [6:0] bg_last;
  } stat_t;

endpackage

// ----- rtl/core/vcva_ctrl.sv -----
// Controller state machine of the voice allocator: sequences the scans and
// issues one datapath command per cycle. Depends on vcva_pkg.
module vcva_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  vcva_pkg::stat_t stat_i,
  output vcva_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SDisp  = 4'd1;
  localparam logic [3:0] SDup   = 4'd2;
  localparam logic [3:0] SMap   = 4'd3;
  localparam logic [3:0] SScan  = 4'd4;
  localparam logic [3:0] SApply = 4'd5;
  localparam logic [3:0] SBg    = 4'd6;
  localparam logic [3:0] SMove  = 4'd7;
  localparam logic [3:0] SFin   = 4'd8;
  localparam logic [3:0] SDone  = 4'd9;
  localparam logic [3:0] SPast  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [6:0] idx_q, idx_d;
  logic [3:0] op;

  assign busy  = (state_q != SIdle);
  assign cmd_o = '{op: op, idx: idx_q};

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    op      = vcva_pkg::OpNone;
    case (state_q)
      SIdle: begin
        if (start) begin
          op      = vcva_pkg::OpLoad;
          state_d = SDisp;
        end
      end
      SDisp: begin
        case (stat_i.func)
          vcva_pkg::FuncTrigger: begin
            if (!stat_i.inrange) begin
              op      = vcva_pkg::OpReject;
              state_d = SIdle;
            end else if (stat_i.dup_en) begin
              idx_d   = 7'd0;
              state_d = SDup;
            end else begin
              state_d = SMap;
            end
          end
          vcva_pkg::FuncCut: begin
            op      = vcva_pkg::OpCutCh;
            state_d = SDone;
          end
          vcva_pkg::FuncPast: begin
            idx_d   = {2'b00, stat_i.nv_last};
            state_d = SPast;
          end
          default: begin
            op      = vcva_pkg::OpStatus;
            state_d = SIdle;
          end
        endcase
      end
      SDup: begin
        op = vcva_pkg::OpDup;
        if (idx_q[4:0] == stat_i.nv_last) state_d = SMap;
        else idx_d = idx_q + 7'd1;
      end
      SMap: begin
        op    = vcva_pkg::OpMap;
        idx_d = 7'd0;
        if (stat_i.map_valid && !(stat_i.sounding && stat_i.multi)) state_d = SFin;
        else state_d = SScan;
      end
      SScan: begin
        op = stat_i.lt_per ? vcva_pkg::OpScanFree : vcva_pkg::OpScanOld;
        if (idx_q[4:0] == stat_i.nv_last) state_d = SApply;
        else idx_d = idx_q + 7'd1;
      end
      SApply: begin
        if (stat_i.found) begin
          op = vcva_pkg::OpApply;
          if (stat_i.had_voc && stat_i.vf_ne_voc) begin
            idx_d   = stat_i.bg_first;
            state_d = SBg;
          end else begin
            state_d = SFin;
          end
        end else if (stat_i.had_voc && !stat_i.strict) begin
          state_d = SFin;
        end else begin
          op      = vcva_pkg::OpReject;
          state_d = SIdle;
        end
      end
      SBg: begin
        op = vcva_pkg::OpScanBg;
        if (idx_q == stat_i.bg_last) state_d = SMove;
        else idx_d = idx_q + 7'd1;
      end
      SMove: begin
        op      = vcva_pkg::OpMove;
        state_d = SFin;
      end
      SFin: begin
        op      = vcva_pkg::OpFinish;
        state_d = SDone;
      end
      SDone: begin
        op      = vcva_pkg::OpDone;
        state_d = SIdle;
      end
      SPast: begin
        op = vcva_pkg::OpPast;
        if (idx_q == 7'd0) state_d = SDone;
        else idx_d = idx_q - 7'd1;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q   <= 7'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == SDisp))
    else $error("accepted request did not reach dispatch");
  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan || state_q == SDup) |-> (idx_q[6:5] == 2'b00))
    else $error("voice scan index out of range");
  a_bg_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SBg) |-> (idx_q >= stat_i.bg_first && idx_q <= stat_i.bg_last))
    else $error("background scan index out of range");
`endif

endmodule

// ----- rtl/core/vcva_dp.sv -----
// Datapath of the voice allocator: configuration, the voice table, scan
// registers and the result register. Depends on vcva_pkg.
module vcva_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [6:0]       cfg_data_i,
  input  logic [1:0]       func_i,
  input  logic [6:0]       channel_i,
  input  logic signed [8:0]  instrument_i,
  input  logic signed [10:0] sample_i,
  input  logic [6:0]       note_i,
  input  logic [1:0]       action_i,
  input  logic [1:0]       dup_check_i,
  input  logic [1:0]       dup_action_i,
  input  logic             strict_alloc_i,
  input  logic             keep_sample_i,
  input  vcva_pkg::cmd_t   cmd_i,
  output vcva_pkg::stat_t  stat_o,
  output logic             result_valid_o,
  output logic [2:0]       kind_o,
  output logic [4:0]       voice_o,
  output logic [6:0]       result_channel_o,
  output logic [9:0]       sample_out_o,
  output logic [6:0]       note_out_o,
  output logic             load_sample_o,
  output logic [2:0]       status_o,
  output logic             last_o
);

  localparam int NV = vcva_pkg::MaxVoices;

  logic [6:0] track_q;
  logic [5:0] vcount_q;
  logic       multi_q;
  logic       clr;

  logic [1:0]  func_q;
  logic [6:0]  chn_q;
  logic [8:0]  ins_q;
  logic [10:0] smp_q;
  logic [6:0]  note_q;
  logic [1:0]  act_q, dct_q, dca_q;
  logic        strict_q, keep_q;

  logic        own_v_q  [NV];
  logic [6:0]  own_q    [NV];
  logic        root_v_q [NV];
  logic [6:0]  root_q   [NV];
  logic [31:0] age_q    [NV];
  logic [8:0]  vins_q   [NV];
  logic [10:0] vsmp_q   [NV];
  logic [6:0]  vnote_q  [NV];
  logic [1:0]  vact_q   [NV];
  logic [31:0] age_ctr_q;

  logic [4:0] voc_q, vf_q;
  logic       had_voc_q, found_q, bg_found_q;
  logic [6:0] bg_q, ret_q;

  logic [6:0] t_eff, nch;
  logic [5:0] p_eff, nv, nv_m1;
  logic       inrange, m_v, lt_per, cand, past_hit, bg_busy;
  logic [4:0] m_idx, iv;
  logic [NV-1:0] root_hit;
  logic [5:0] root_cnt;

  logic       fr_en;
  logic [4:0] fr_v;
  logic       em_en, em_load;
  logic [2:0] em_kind, em_status;
  logic [4:0] em_voice;
  logic [6:0] em_rch, em_note;
  logic [9:0] em_smp;

  assign clr = cfg_we_i && (cfg_idx_i == vcva_pkg::CfgTracks ||
               cfg_idx_i == vcva_pkg::CfgVoices || cfg_idx_i == vcva_pkg::CfgMulti);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q  <= 7'd4;
      vcount_q <= 6'd32;
      multi_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vcva_pkg::CfgTracks: track_q  <= cfg_data_i;
        vcva_pkg::CfgVoices: vcount_q <= cfg_data_i[5:0];
        vcva_pkg::CfgMulti:  multi_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (track_q == 7'd0) t_eff = 7'd1;
    else if (track_q > 7'(vcva_pkg::MaxTracks)) t_eff = 7'(vcva_pkg::MaxTracks);
    else t_eff = track_q;
    if (vcount_q == 6'd0) p_eff = 6'd1;
    else if (vcount_q > 6'(vcva_pkg::MaxVoices)) p_eff = 6'(vcva_pkg::MaxVoices);
    else p_eff = vcount_q;
    // Without multi-voice mode the pool never exceeds the track count.
    if (!multi_q && {1'b0, p_eff} > t_eff) nv = t_eff[5:0];
    else nv = p_eff;
    nch = multi_q ? (t_eff + {1'b0, p_eff}) : t_eff;
  end

  assign nv_m1   = nv - 6'd1;
  assign inrange = (chn_q < nch);
  assign iv      = cmd_i.idx[4:0];

  // Channel lookups come from the voice table: a channel is mapped to the one
  // voice that it owns, and its voice count is the number of voices rooted on it.
  always_comb begin
    m_v      = 1'b0;
    m_idx    = 5'd0;
    bg_busy  = 1'b0;
    root_hit = '0;
    for (int v = 0; v < NV; v++) begin
      if (own_v_q[v] && own_q[v] == chn_q) begin
        m_v   = 1'b1;
        m_idx = 5'(v);
      end
      if (own_v_q[v] && own_q[v] == cmd_i.idx) bg_busy = 1'b1;
      root_hit[v] = root_v_q[v] && (root_q[v] == chn_q);
    end
  end

  assign root_cnt = 6'($countones(root_hit));
  assign lt_per   = multi_q ? (root_cnt < 6'(vcva_pkg::VoicesPerChan)) : (root_cnt == 6'd0);

  always_comb begin
    cand = root_v_q[iv] && (root_q[iv] == chn_q) && (vins_q[iv] == ins_q);
    case (dct_q)
      2'd1:    cand = cand;
      2'd2:    cand = cand && (vsmp_q[iv] == smp_q);
      2'd3:    cand = cand && (vnote_q[iv] == note_q);
      default: cand = 1'b0;
    endcase
  end

  assign past_hit = root_v_q[iv] && (root_q[iv] == chn_q) && own_v_q[iv] &&
                    (own_q[iv] >= t_eff);

  always_comb begin
    stat_o.func      = func_q;
    stat_o.inrange   = inrange;
    stat_o.dup_en    = (dct_q != 2'd0);
    stat_o.map_valid = m_v;
    stat_o.sounding  = (vact_q[m_idx] != 2'd0);
    stat_o.multi     = multi_q;
    stat_o.lt_per    = lt_per;
    stat_o.found     = found_q;
    stat_o.vf_ne_voc = (vf_q != voc_q);
    stat_o.had_voc   = had_voc_q;
    stat_o.strict    = strict_q;
    stat_o.nv_last   = nv_m1[4:0];
    stat_o.bg_first  = t_eff;
    stat_o.bg_last   = nch - 7'd1;
  end

  // Freeing a voice and the result that one command produces.
  always_comb begin
    fr_en     = 1'b0;
    fr_v      = iv;
    em_en     = 1'b0;
    em_kind   = vcva_pkg::KindSilence;
    em_rch    = 7'd0;
    em_smp    = 10'd0;
    em_note   = 7'd0;
    em_load   = 1'b0;
    em_status = 3'd0;
    case (cmd_i.op)
      vcva_pkg::OpDup: begin
        fr_en = cand && (dca_q == 2'd0);
      end
      vcva_pkg::OpCutCh: begin
        fr_en = inrange && m_v;
        fr_v  = m_idx;
      end
      vcva_pkg::OpPast: begin
        fr_en = past_hit && (act_q == 2'd0);
      end
      vcva_pkg::OpMove: begin
        fr_en = !bg_found_q;
        fr_v  = voc_q;
      end
      vcva_pkg::OpFinish: begin
        fr_v = voc_q;
        if (smp_q[10]) begin
          fr_en = 1'b1;
        end else begin
          em_en   = 1'b1;
          em_kind = vcva_pkg::KindStart;
          em_rch  = ret_q;
          em_smp  = smp_q[9:0];
          em_note = note_q;
          em_load = !keep_q;
        end
      end
      vcva_pkg::OpDone: begin
        em_en   = 1'b1;
        em_kind = vcva_pkg::KindDone;
        em_rch  = (func_q == vcva_pkg::FuncTrigger) ? ret_q : 7'd0;
      end
      vcva_pkg::OpReject: begin
        em_en   = 1'b1;
        em_kind = vcva_pkg::KindReject;
      end
      vcva_pkg::OpStatus: begin
        em_en   = 1'b1;
        em_kind = vcva_pkg::KindStatus;
        if (!(inrange && m_v)) em_status = vcva_pkg::StatInvalid;
        else if (chn_q < t_eff) em_status = vcva_pkg::StatFg;
        else em_status = {1'b0, vact_q[m_idx]};
      end
      default: ;
    endcase
    if (fr_en) begin
      em_en   = 1'b1;
      em_kind = vcva_pkg::KindSilence;
    end
    em_voice = (fr_en || em_kind == vcva_pkg::KindStart) ? fr_v : 5'd0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == vcva_pkg::OpLoad) begin
      func_q   <= func_i;
      chn_q    <= channel_i;
      ins_q    <= instrument_i;
      smp_q    <= instrument_i[8] ? 11'h7FF : sample_i;
      note_q   <= note_i;
      act_q    <= action_i;
      dct_q    <= dup_check_i;
      dca_q    <= dup_action_i;
      strict_q <= strict_alloc_i;
      keep_q   <= keep_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NV; i++) begin
        own_v_q[i] <= 1'b0;  own_q[i]  <= 7'd0;
        root_v_q[i] <= 1'b0; root_q[i] <= 7'd0;
        age_q[i] <= 32'd0;   vins_q[i] <= 9'd0;
        vsmp_q[i] <= 11'd0;  vnote_q[i] <= 7'd0; vact_q[i] <= 2'd0;
      end
      age_ctr_q  <= 32'd0;
      voc_q      <= 5'd0;
      vf_q       <= 5'd0;
      had_voc_q  <= 1'b0;
      found_q    <= 1'b0;
      bg_found_q <= 1'b0;
      bg_q       <= 7'd0;
      ret_q      <= 7'd0;
    end else if (clr) begin
      for (int i = 0; i < NV; i++) begin
        own_v_q[i] <= 1'b0;  own_q[i]  <= 7'd0;
        root_v_q[i] <= 1'b0; root_q[i] <= 7'd0;
        age_q[i] <= 32'd0;   vins_q[i] <= 9'd0;
        vsmp_q[i] <= 11'd0;  vnote_q[i] <= 7'd0; vact_q[i] <= 2'd0;
      end
      age_ctr_q <= 32'd0;
    end else begin
      case (cmd_i.op)
        vcva_pkg::OpLoad: ret_q <= channel_i;
        vcva_pkg::OpDup: begin
          if (cand && dca_q != 2'd0 &&
              (!(m_v && m_idx == iv) || vact_q[iv] != 2'd0)) begin
            vact_q[iv] <= dca_q;
          end
        end
        vcva_pkg::OpPast: begin
          if (past_hit && act_q != 2'd0) vact_q[iv] <= act_q;
        end
        vcva_pkg::OpMap: begin
          voc_q     <= m_idx;
          had_voc_q <= m_v;
          found_q   <= 1'b0;
        end
        vcva_pkg::OpScanFree: begin
          if (!found_q && !own_v_q[iv]) begin
            found_q <= 1'b1;
            vf_q    <= iv;
          end
        end
        vcva_pkg::OpScanOld: begin
          if (root_v_q[iv] && root_q[iv] == chn_q && (!found_q || age_q[iv] < age_q[vf_q]))
          begin
            found_q <= 1'b1;
            vf_q    <= iv;
          end
        end
        vcva_pkg::OpApply: begin
          // Taking ownership also releases the channel a stolen voice was on.
          age_q[vf_q]    <= age_ctr_q;
          own_v_q[vf_q]  <= 1'b1;
          own_q[vf_q]    <= chn_q;
          root_v_q[vf_q] <= 1'b1;
          root_q[vf_q]   <= chn_q;
          if (!had_voc_q) voc_q <= vf_q;
          bg_found_q <= 1'b0;
        end
        vcva_pkg::OpScanBg: begin
          if (!bg_found_q && !bg_busy) begin
            bg_found_q <= 1'b1;
            bg_q       <= cmd_i.idx;
          end
        end
        vcva_pkg::OpMove: begin
          if (bg_found_q) begin
            own_q[voc_q] <= bg_q;
            ret_q        <= bg_q;
          end
          voc_q <= vf_q;
        end
        vcva_pkg::OpFinish: begin
          if (!smp_q[10]) begin
            if (!keep_q) vsmp_q[voc_q] <= smp_q;
            vnote_q[voc_q] <= note_q;
            vins_q[voc_q]  <= ins_q;
            vact_q[voc_q]  <= act_q;
            age_ctr_q      <= age_ctr_q + 32'd1;
          end
        end
        default: ;
      endcase
      if (fr_en) begin
        own_v_q[fr_v]  <= 1'b0;
        own_q[fr_v]    <= 7'd0;
        root_v_q[fr_v] <= 1'b0;
        root_q[fr_v]   <= 7'd0;
        age_q[fr_v]    <= 32'd0;
        vins_q[fr_v]   <= 9'd0;
        vsmp_q[fr_v]   <= 11'd0;
        vnote_q[fr_v]  <= 7'd0;
        vact_q[fr_v]   <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= em_en;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_o           <= em_kind;
    voice_o          <= em_voice;
    result_channel_o <= em_rch;
    sample_out_o     <= em_smp;
    note_out_o       <= em_note;
    load_sample_o    <= em_load;
    status_o         <= em_status;
    last_o           <= (em_kind == vcva_pkg::KindReject || em_kind == vcva_pkg::KindStatus ||
                         em_kind == vcva_pkg::KindDone);
  end

endmodule

// ----- rtl/core/virtual_channel_voice_allocator_top.sv -----
// Top level of the voice allocator: joins the controller and the datapath.
// Depends on vcva_pkg, vcva_ctrl and vcva_dp.

// A request is taken when start is high and busy is low; busy falls in the
// cycle in which the last result is on the ports. The controller walks the
// voice table one entry per cycle. A trigger may scan the voices for duplicates,
// scan them for a free voice or the channel's oldest voice and, when a voice
// moves, scan the background channels; the duplicate scan and the allocation
// scan are skipped when not needed. A past-note request also walks the voice
// table. Results appear on result_valid_o and must be taken in that cycle;
// last_o marks the final one. A write to the tracks, voices or multi
// configuration register clears all voice and channel state.
module virtual_channel_voice_allocator_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [6:0]        cfg_data_i,
  input  logic [1:0]        func_i,
  input  logic [6:0]        channel_i,
  input  logic signed [8:0]  instrument_i,
  input  logic signed [10:0] sample_i,
  input  logic [6:0]        note_i,
  input  logic [1:0]        action_i,
  input  logic [1:0]        dup_check_i,
  input  logic [1:0]        dup_action_i,
  input  logic              strict_alloc_i,
  input  logic              keep_sample_i,
  output logic              result_valid_o,
  output logic [2:0]        kind_o,
  output logic [4:0]        voice_o,
  output logic [6:0]        result_channel_o,
  output logic [9:0]        sample_out_o,
  output logic [6:0]        note_out_o,
  output logic              load_sample_o,
  output logic [2:0]        status_o,
  output logic              last_o
);

  vcva_pkg::cmd_t  cmd;
  vcva_pkg::stat_t stat;

  vcva_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  vcva_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .func_i           (func_i),
    .channel_i        (channel_i),
    .instrument_i     (instrument_i),
    .sample_i         (sample_i),
    .note_i           (note_i),
    .action_i         (action_i),
    .dup_check_i      (dup_check_i),
    .dup_action_i     (dup_action_i),
    .strict_alloc_i   (strict_alloc_i),
    .keep_sample_i    (keep_sample_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .result_valid_o   (result_valid_o),
    .kind_o           (kind_o),
    .voice_o          (voice_o),
    .result_channel_o (result_channel_o),
    .sample_out_o     (sample_out_o),
    .note_out_o       (note_out_o),
    .load_sample_o    (load_sample_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule

// ----- bench/vcva_voice_checker.sv -----
// Scoreboard for the voice allocator: watches requests, configuration writes and
// mixer commands, predicts each command and compares it. Depends on vcva_pkg.
module vcva_voice_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [6:0]        cfg_data_i,
  input  logic [1:0]        func_i,
  input  logic [6:0]        channel_i,
  input  logic signed [8:0]  instrument_i,
  input  logic signed [10:0] sample_i,
  input  logic [6:0]        note_i,
  input  logic [1:0]        action_i,
  input  logic [1:0]        dup_check_i,
  input  logic [1:0]        dup_action_i,
  input  logic              strict_alloc_i,
  input  logic              keep_sample_i,
  input  logic              result_valid_o,
  input  logic [2:0]        kind_o,
  input  logic [4:0]        voice_o,
  input  logic [6:0]        result_channel_o,
  input  logic [9:0]        sample_out_o,
  input  logic [6:0]        note_out_o,
  input  logic              load_sample_o,
  input  logic [2:0]        status_o,
  input  logic              last_o,
  output int                pending_o,
  output int                errors_o,
  output int                commands_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] voice;
    logic [6:0] rch;
    logic [9:0] smp;
    logic [6:0] note;
    logic       load;
    logic [2:0] status;
    logic       last;
  } mixer_cmd_t;

  mixer_cmd_t expected_cmds[$];
  mixer_cmd_t request_cmds[$];

  // Allocator image: voice table, channel map and counters.
  int          owner [vcva_pkg::MaxVoices];
  int          root  [vcva_pkg::MaxVoices];
  logic [31:0] age   [vcva_pkg::MaxVoices];
  int          v_ins [vcva_pkg::MaxVoices];
  int          v_smp [vcva_pkg::MaxVoices];
  logic [6:0]  v_note[vcva_pkg::MaxVoices];
  logic [1:0]  v_act [vcva_pkg::MaxVoices];
  int          ch_map[vcva_pkg::NumChan];
  int          ch_cnt[vcva_pkg::NumChan];
  int          used_voices;
  logic [31:0] age_now;
  int          reg_tracks, reg_voices;
  bit          reg_multi;
  int          n_errors, n_cmds;

  function automatic int tracks_in_use();
    return reg_tracks < 1 ? 1 :
           (reg_tracks > vcva_pkg::MaxTracks ? vcva_pkg::MaxTracks : reg_tracks);
  endfunction

  function automatic int pool_size();
    return reg_voices < 1 ? 1 :
           (reg_voices > vcva_pkg::MaxVoices ? vcva_pkg::MaxVoices : reg_voices);
  endfunction

  function automatic int voices_in_use();
    int nv;
    nv = pool_size();
    if (!reg_multi && nv > tracks_in_use()) nv = tracks_in_use();
    return nv;
  endfunction

  function automatic int channels_in_use();
    return reg_multi ? tracks_in_use() + pool_size() : tracks_in_use();
  endfunction

  function automatic void wipe_voice(int v);
    owner[v] = -1;
    root[v] = -1;
    age[v] = '0;
    v_ins[v] = 0;
    v_smp[v] = 0;
    v_note[v] = '0;
    v_act[v] = '0;
  endfunction

  function automatic void wipe_all();
    for (int i = 0; i < vcva_pkg::MaxVoices; i++) wipe_voice(i);
    for (int i = 0; i < vcva_pkg::NumChan; i++) begin
      ch_map[i] = -1;
      ch_cnt[i] = 0;
    end
    used_voices = 0;
    age_now = '0;
  endfunction

  function automatic void add_cmd(logic [2:0] kind, int voice, int rch, int smp, int note,
                                  bit load, logic [2:0] status);
    mixer_cmd_t c;
    c.kind = kind;
    c.voice = voice[4:0];
    c.rch = rch[6:0];
    c.smp = smp[9:0];
    c.note = note[6:0];
    c.load = load;
    c.status = status;
    c.last = 1'b0;
    request_cmds.push_back(c);
  endfunction

  function automatic void silence_voice(int v);
    int o, r;
    o = owner[v];
    r = root[v];
    add_cmd(vcva_pkg::KindSilence, v, 0, 0, 0, 0, 0);
    if (o >= 0 && ch_map[o] == v) ch_map[o] = -1;
    if (r >= 0 && ch_cnt[r] > 0) ch_cnt[r]--;
    if (used_voices > 0) used_voices--;
    wipe_voice(v);
  endfunction

  // First free voice while under the per-channel limit, else steal the oldest.
  function automatic int grab_voice(int chn);
    int i, best, nv, per;
    best = -1;
    nv = voices_in_use();
    per = reg_multi ? vcva_pkg::VoicesPerChan : 1;
    if (ch_cnt[chn] < per) begin
      for (i = 0; i < nv; i++)
        if (owner[i] == -1) break;
      if (i == nv) return -1;
      age[i] = age_now;
      ch_cnt[chn]++;
      used_voices++;
      return i;
    end
    for (i = 0; i < nv; i++)
      if (root[i] == chn && (best < 0 || age[i] < age[best])) best = i;
    if (best < 0) return -1;
    i = owner[best];
    if (i >= 0 && ch_map[i] == best) ch_map[i] = -1;
    age[best] = age_now;
    return best;
  endfunction

  function automatic void predict_trigger();
    int nv, chn, ins, smp, voc, vf, ret, b, nch;
    nv = voices_in_use();
    chn = channel_i;
    ins = instrument_i;
    smp = sample_i;
    if (chn >= channels_in_use()) begin
      add_cmd(vcva_pkg::KindReject, 0, 0, 0, 0, 0, 0);
      return;
    end
    if (ins < 0) smp = -1;
    if (dup_check_i != 0) begin
      for (int v = 0; v < nv; v++) begin
        if (root[v] != chn || v_ins[v] != ins) continue;
        if (dup_check_i == 1 || (dup_check_i == 2 && v_smp[v] == smp) ||
            (dup_check_i == 3 && v_note[v] == note_i)) begin
          if (dup_action_i != 0) begin
            if (ch_map[chn] != v || v_act[v] != 0) v_act[v] = dup_action_i;
          end else begin
            silence_voice(v);
          end
        end
      end
    end
    voc = ch_map[chn];
    ret = chn;
    if (voc >= 0) begin
      if (v_act[voc] != 0 && reg_multi) begin
        vf = grab_voice(chn);
        if (vf >= 0) begin
          root[vf] = chn;
          owner[vf] = chn;
          ch_map[chn] = vf;
          if (vf != voc) begin
            // The displaced voice keeps sounding on a free background channel, else it is silenced.
            nch = channels_in_use();
            for (b = tracks_in_use(); b < nch; b++)
              if (ch_map[b] == -1) break;
            if (b < nch) begin
              owner[voc] = b;
              ch_map[b] = voc;
              ret = b;
            end else begin
              silence_voice(voc);
            end
            voc = vf;
          end
        end else if (strict_alloc_i) begin
          add_cmd(vcva_pkg::KindReject, 0, 0, 0, 0, 0, 0);
          return;
        end
      end
    end else begin
      vf = grab_voice(chn);
      if (vf < 0) begin
        add_cmd(vcva_pkg::KindReject, 0, 0, 0, 0, 0, 0);
        return;
      end
      ch_map[chn] = vf;
      owner[vf] = chn;
      root[vf] = chn;
      voc = vf;
    end
    if (smp < 0) begin
      silence_voice(voc);
    end else begin
      add_cmd(vcva_pkg::KindStart, voc, ret, smp, note_i, !keep_sample_i, 0);
      if (!keep_sample_i) v_smp[voc] = smp;
      v_note[voc] = note_i;
      v_ins[voc] = ins;
      v_act[voc] = action_i;
      age_now++;
    end
    add_cmd(vcva_pkg::KindDone, 0, ret, 0, 0, 0, 0);
  endfunction

  function automatic void predict_request();
    int chn;
    bit inrange;
    logic [2:0] st;
    chn = channel_i;
    inrange = chn < channels_in_use();
    request_cmds.delete();
    case (func_i)
      vcva_pkg::FuncTrigger: predict_trigger();
      vcva_pkg::FuncCut: begin
        if (inrange && ch_map[chn] >= 0) silence_voice(ch_map[chn]);
        add_cmd(vcva_pkg::KindDone, 0, 0, 0, 0, 0, 0);
      end
      vcva_pkg::FuncPast: begin
        for (int v = voices_in_use() - 1; v >= 0; v--) begin
          if (root[v] == chn && owner[v] >= tracks_in_use()) begin
            if (action_i == 0) silence_voice(v);
            else v_act[v] = action_i;
          end
        end
        add_cmd(vcva_pkg::KindDone, 0, 0, 0, 0, 0, 0);
      end
      default: begin
        st = vcva_pkg::StatInvalid;
        if (inrange && ch_map[chn] >= 0)
          st = (chn < tracks_in_use()) ? vcva_pkg::StatFg : {1'b0, v_act[ch_map[chn]]};
        add_cmd(vcva_pkg::KindStatus, 0, 0, 0, 0, 0, st);
      end
    endcase
    request_cmds[request_cmds.size() - 1].last = 1'b1;
    foreach (request_cmds[i]) expected_cmds.push_back(request_cmds[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mixer_cmd_t got, want;
    if (!rst_ni) begin
      reg_tracks = 4;
      reg_voices = 32;
      reg_multi = 1'b0;
      wipe_all();
      expected_cmds.delete();
      n_errors = 0;
      n_cmds = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          vcva_pkg::CfgTracks: reg_tracks = cfg_data_i;
          vcva_pkg::CfgVoices: reg_voices = cfg_data_i[5:0];
          vcva_pkg::CfgMulti:  reg_multi = cfg_data_i[0];
          default: ;
        endcase
        if (cfg_idx_i == vcva_pkg::CfgTracks || cfg_idx_i == vcva_pkg::CfgVoices ||
            cfg_idx_i == vcva_pkg::CfgMulti) wipe_all();
      end
      if (start && !busy) predict_request();
      if (result_valid_o) begin
        got = '{kind_o, voice_o, result_channel_o, sample_out_o, note_out_o,
                load_sample_o, status_o, last_o};
        n_cmds++;
        if (expected_cmds.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: unexpected command kind=%0d voice=%0d ch=%0d", kind_o, voice_o,
                     result_channel_o);
        end else begin
          want = expected_cmds.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("ERROR: command mismatch");
              $display("  exp kind=%0d voice=%0d ch=%0d smp=%0d note=%0d load=%0d st=%0d last=%0d",
                       want.kind, want.voice, want.rch, want.smp, want.note, want.load,
                       want.status, want.last);
              $display("  got kind=%0d voice=%0d ch=%0d smp=%0d note=%0d load=%0d st=%0d last=%0d",
                       got.kind, got.voice, got.rch, got.smp, got.note, got.load,
                       got.status, got.last);
            end
          end
        end
      end
    end
    pending_o = expected_cmds.size();
    errors_o = n_errors;
    commands_o = n_cmds;
  end

endmodule

// ----- bench/tb_virtual_channel_voice_allocator_top.sv -----
// Testbench top for the voice allocator: clock, reset, requests and configuration
// writes, and the verdict. Depends on vcva_pkg, the block and vcva_voice_checker.
module tb_virtual_channel_voice_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  logic              clk_i, rst_ni, start, busy, cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [6:0]        cfg_data_i;
  logic [1:0]        func_i;
  logic [6:0]        channel_i;
  logic signed [8:0]  instrument_i;
  logic signed [10:0] sample_i;
  logic [6:0]        note_i;
  logic [1:0]        action_i, dup_check_i, dup_action_i;
  logic              strict_alloc_i, keep_sample_i;
  logic              result_valid_o, load_sample_o, last_o;
  logic [2:0]        kind_o, status_o;
  logic [4:0]        voice_o;
  logic [6:0]        result_channel_o, note_out_o;
  logic [9:0]        sample_out_o;
  int                pending, errors, commands, cycles, requests;
  int                cur_channels;

  virtual_channel_voice_allocator_top u_dut (.*);

  vcva_voice_checker u_checker (
    .*,
    .pending_o (pending),
    .errors_o  (errors),
    .commands_o(commands)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_virtual_channel_voice_allocator_top: done, errors");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] fn, int chn, int ins, int smp, int note,
                              int act, int dck, int dact, bit strict, bit keep);
    int gap;
    gap = $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start = 1'b1;
    func_i = fn;
    channel_i = chn[6:0];
    instrument_i = ins[8:0];
    sample_i = smp[10:0];
    note_i = note[6:0];
    action_i = act[1:0];
    dup_check_i = dck[1:0];
    dup_action_i = dact[1:0];
    strict_alloc_i = strict;
    keep_sample_i = keep;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    requests++;
  endtask

  // Lets all commands drain and the block go idle before a write.
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, int value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value[6:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_request();
    int fn, chn, ins, smp, note, act, pick;
    pick = $urandom_range(0, 99);
    fn = pick < 60 ? vcva_pkg::FuncTrigger : pick < 75 ? vcva_pkg::FuncCut :
         pick < 90 ? vcva_pkg::FuncPast : vcva_pkg::FuncStatus;
    chn = $urandom_range(0, 99) < 88 ? $urandom_range(0, cur_channels - 1)
                                     : $urandom_range(0, 127);
    pick = $urandom_range(0, 99);
    ins = pick < 80 ? $urandom_range(1, 3) : pick < 86 ? -1 : $urandom_range(0, 255);
    pick = $urandom_range(0, 99);
    smp = pick < 80 ? $urandom_range(0, 3) : pick < 86 ? -1 : $urandom_range(0, 1023);
    note = $urandom_range(0, 99) < 70 ? $urandom_range(60, 62) : $urandom_range(0, 127);
    // Mostly sounding actions, so multi mode keeps allocating extra voices.
    act = $urandom_range(0, 99) < 80 ? $urandom_range(1, 3) : 0;
    send_request(fn[1:0], chn, ins, smp, note, act, $urandom_range(0, 3),
                 $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  initial begin
    int trk[8] = '{1, 64, 4, 2, 64, 1, 0, 3};
    int vce[8] = '{1, 32, 8, 32, 32, 1, 0, 5};
    int mlt[8] = '{0, 0, 1, 1, 1, 1, 0, 1};
    int t, p;
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = vcva_pkg::CfgTracks;
    cfg_data_i = '0;
    func_i = vcva_pkg::FuncTrigger;
    channel_i = '0;
    instrument_i = '0;
    sample_i = '0;
    note_i = '0;
    action_i = '0;
    dup_check_i = '0;
    dup_action_i = '0;
    strict_alloc_i = 1'b0;
    keep_sample_i = 1'b0;
    cycles = 0;
    requests = 0;
    cur_channels = 4;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset configuration.
    send_request(vcva_pkg::FuncStatus, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(vcva_pkg::FuncTrigger, 0, 255, 1023, 127, 3, 0, 0, 0, 0);
    send_request(vcva_pkg::FuncStatus, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(vcva_pkg::FuncTrigger, 0, 255, 1023, 127, 1, 3, 2, 0, 1);
    send_request(vcva_pkg::FuncTrigger, 0, 255, 5, 0, 2, 2, 0, 0, 0);
    send_request(vcva_pkg::FuncTrigger, 0, 255, 1023, 1, 0, 1, 0, 1, 0);
    send_request(vcva_pkg::FuncTrigger, 1, -1, 7, 10, 3, 0, 0, 0, 0);
    send_request(vcva_pkg::FuncTrigger, 2, 3, -1, 10, 3, 0, 0, 0, 0);
    send_request(vcva_pkg::FuncTrigger, 127, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(vcva_pkg::FuncTrigger, 3, 0, 0, 0, 1, 0, 0, 0, 0);
    send_request(vcva_pkg::FuncStatus, 3, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(vcva_pkg::FuncStatus, 127, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(vcva_pkg::FuncPast, 3, 0, 0, 0, 2, 0, 0, 0, 0);
    send_request(vcva_pkg::FuncPast, 3, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(vcva_pkg::FuncCut, 3, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(vcva_pkg::FuncCut, 3, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(vcva_pkg::FuncCut, 127, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(vcva_pkg::FuncTrigger, 1, 128, 512, 64, 2, 3, 1, 1, 1);

    for (p = 0; p < 8; p++) begin
      drain();
      write_cfg(vcva_pkg::CfgTracks, trk[p]);
      write_cfg(vcva_pkg::CfgVoices, vce[p]);
      write_cfg(vcva_pkg::CfgMulti, mlt[p]);
      t = trk[p] < 1 ? 1 : trk[p];
      cur_channels = mlt[p] ? t + (vce[p] < 1 ? 1 : vce[p]) : t;
      for (int i = 0; i < 23; i++) begin
        random_request();
        if (p == 3 && i == 11) begin
          @(negedge clk_i);
          start = 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests over 9 register settings, single and multi voice mode;",
             requests);
    $display("checked %0d mixer commands, %0d mismatches.", commands, errors);
    if (errors == 0 && pending == 0) begin
      $display("tb_virtual_channel_voice_allocator_top: done, clean");
    end else begin
      $display("tb_virtual_channel_voice_allocator_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- virtual_channel_voice_allocator_top.f -----
rtl/core/vcva_pkg.sv
rtl/core/vcva_ctrl.sv
rtl/core/vcva_dp.sv
rtl/core/virtual_channel_voice_allocator_top.sv
bench/vcva_voice_checker.sv
bench/tb_virtual_channel_voice_allocator_top.sv
